### rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/qtrm_pkg.sv
package qtrm_pkg;
    localparam int LANES   = 9;
    localparam int QBITS   = 15;
    localparam int NRM_W   = 33;
    localparam int NUM_W   = 35;
    localparam int REM_W   = NRM_W + QBITS + 1;
    localparam logic [QBITS-1:0] ONE_Q14 = 15'd16384;

    typedef logic [REM_W-1:0] t_rem;
    typedef logic [QBITS-1:0] t_quo;
    typedef logic [NRM_W-1:0] t_nrm;
endpackage

### rtl/quaternion_to_rotation_matrix.sv
// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// input   | i_valid, o_stall, i_quat_x/y/z/w          | in
// output  | o_valid, i_stall, o_r00..o_r22, o_zero_norm | out
//
// One item per cycle enters while the output is not stalled; each item passes
// through the products, norm and numerators, sign and dividend registers, then
// 15 restoring-divide stages, one bit each, and the output register.
// The 15-stage quotient pipeline makes up most of the depth.
// Reset (i_rst_n low, synchronous) clears all valid bits.
// A stalled output freezes the whole pipeline; o_stall follows at once.
`include "assert_macros.svh"

module quaternion_to_rotation_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_r00,
    output logic signed [15:0] o_r01,
    output logic signed [15:0] o_r02,
    output logic signed [15:0] o_r10,
    output logic signed [15:0] o_r11,
    output logic signed [15:0] o_r12,
    output logic signed [15:0] o_r20,
    output logic signed [15:0] o_r21,
    output logic signed [15:0] o_r22,
    output logic               o_zero_norm
);
    localparam int L  = qtrm_pkg::LANES;
    localparam int QB = qtrm_pkg::QBITS;

    // Output valid, driven by the output stage below.
    logic r_vo;

    // Pipeline advances as a whole unless the output item is held.
    logic en;
    assign en      = !(r_vo && i_stall);
    assign o_stall = r_vo && i_stall;

    // Stage 1: squares and cross products.
    logic               r_v1;
    logic [30:0]        r_xx, r_yy, r_zz, r_ww;
    logic signed [31:0] r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    logic signed [31:0] n_xx, n_yy, n_zz, n_ww;
    always_comb begin
        n_xx = i_quat_x * i_quat_x;
        n_yy = i_quat_y * i_quat_y;
        n_zz = i_quat_z * i_quat_z;
        n_ww = i_quat_w * i_quat_w;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx <= n_xx[30:0];
            r_yy <= n_yy[30:0];
            r_zz <= n_zz[30:0];
            r_ww <= n_ww[30:0];
            r_xy <= i_quat_x * i_quat_y;
            r_zw <= i_quat_z * i_quat_w;
            r_xz <= i_quat_x * i_quat_z;
            r_yw <= i_quat_y * i_quat_w;
            r_yz <= i_quat_y * i_quat_z;
            r_xw <= i_quat_x * i_quat_w;
        end
    end

    // Stage 2: norm and signed numerators.
    qtrm_pkg::t_nrm n_nrm;
    logic [32:0]                         s_yz, s_xz, s_xy;
    logic signed [qtrm_pkg::NUM_W-1:0]   n_num [L];
    logic signed [qtrm_pkg::NUM_W-1:0]   nn;
    logic signed [33:0]                  d_a, d_b, d_c, d_d, d_e, d_f;
    logic signed [qtrm_pkg::NUM_W-1:0]   mag_s [L];
    logic [L-1:0]                        n_neg;
    qtrm_pkg::t_rem                      n_dvd [L];

    logic                                r_v2;
    qtrm_pkg::t_nrm                      r_nrm;
    logic signed [qtrm_pkg::NUM_W-1:0]   r_num [L];

    function automatic logic signed [33:0] ext32(input logic signed [31:0] a);
        ext32 = {{2{a[31]}}, a};
    endfunction

    always_comb begin
        n_nrm = {2'b00, r_xx} + {2'b00, r_yy} + {2'b00, r_zz} + {2'b00, r_ww};
        s_yz  = {2'b00, r_yy} + {2'b00, r_zz};
        s_xz  = {2'b00, r_xx} + {2'b00, r_zz};
        s_xy  = {2'b00, r_xx} + {2'b00, r_yy};
        nn    = $signed({2'b00, n_nrm});
        d_a   = ext32(r_xy) - ext32(r_zw);
        d_b   = ext32(r_xz) + ext32(r_yw);
        d_c   = ext32(r_xy) + ext32(r_zw);
        d_d   = ext32(r_yz) - ext32(r_xw);
        d_e   = ext32(r_xz) - ext32(r_yw);
        d_f   = ext32(r_yz) + ext32(r_xw);
        n_num[0] = nn - $signed({1'b0, s_yz, 1'b0});
        n_num[1] = $signed({d_a, 1'b0});
        n_num[2] = $signed({d_b, 1'b0});
        n_num[3] = $signed({d_c, 1'b0});
        n_num[4] = nn - $signed({1'b0, s_xz, 1'b0});
        n_num[5] = $signed({d_d, 1'b0});
        n_num[6] = $signed({d_e, 1'b0});
        n_num[7] = $signed({d_f, 1'b0});
        n_num[8] = nn - $signed({1'b0, s_xy, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nrm <= n_nrm;
            for (int l = 0; l < L; l++) begin
                r_num[l] <= n_num[l];
            end
        end
    end

    // Stage 3: sign and magnitude, rounded dividend.
    always_comb begin
        for (int l = 0; l < L; l++) begin
            n_neg[l] = r_num[l][qtrm_pkg::NUM_W-1];
            mag_s[l] = n_neg[l] ? -r_num[l] : r_num[l];
            // mag <= norm, so 33 bits hold it.
            n_dvd[l] = {1'b0, mag_s[l][32:0], {QB{1'b0}}} + {{(QB+1){1'b0}}, r_nrm};
        end
    end

    // Divide stages: index 0 holds the dividend, index QB the quotient.
    logic           r_dv   [QB+1];
    qtrm_pkg::t_nrm r_den  [QB+1];
    logic [L-1:0]   r_neg  [QB+1];
    logic           r_zero [QB+1];
    qtrm_pkg::t_rem r_rem  [QB+1][L];
    qtrm_pkg::t_quo r_quo  [QB+1][L];

    qtrm_pkg::t_rem n_rem  [QB][L];
    qtrm_pkg::t_quo n_quo  [QB][L];
    qtrm_pkg::t_rem sh     [QB];
    logic           ge     [QB][L];

    always_comb begin
        for (int s = 0; s < QB; s++) begin
            // Compare against 2n weighted by the current quotient bit.
            sh[s] = {{QB{1'b0}}, r_den[s], 1'b0} << (QB - 1 - s);
            for (int l = 0; l < L; l++) begin
                ge[s][l]    = r_rem[s][l] >= sh[s];
                n_rem[s][l] = ge[s][l] ? r_rem[s][l] - sh[s] : r_rem[s][l];
                n_quo[s][l] = {r_quo[s][l][QB-2:0], ge[s][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QB; s++) begin
                r_dv[s] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r_v2;
            for (int s = 0; s < QB; s++) begin
                r_dv[s+1] <= r_dv[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den[0]  <= r_nrm;
            r_neg[0]  <= n_neg;
            r_zero[0] <= (r_nrm == '0);
            for (int l = 0; l < L; l++) begin
                r_rem[0][l] <= n_dvd[l];
                r_quo[0][l] <= '0;
            end
            for (int s = 0; s < QB; s++) begin
                r_den[s+1]  <= r_den[s];
                r_neg[s+1]  <= r_neg[s];
                r_zero[s+1] <= r_zero[s];
                for (int l = 0; l < L; l++) begin
                    r_rem[s+1][l] <= n_rem[s][l];
                    r_quo[s+1][l] <= n_quo[s][l];
                end
            end
        end
    end

    // Output stage: clamp, apply sign, force zero for a null quaternion.
    logic signed [15:0]  r_out [L];
    logic                r_zn;
    logic signed [15:0]  n_out [L];
    qtrm_pkg::t_quo      sat;

    always_comb begin
        sat = '0;
        for (int l = 0; l < L; l++) begin
            sat = (r_quo[QB][l] > qtrm_pkg::ONE_Q14) ? qtrm_pkg::ONE_Q14 : r_quo[QB][l];
            if (r_zero[QB]) begin
                n_out[l] = '0;
            end else if (r_neg[QB][l]) begin
                n_out[l] = -$signed({1'b0, sat});
            end else begin
                n_out[l] = $signed({1'b0, sat});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zn <= r_zero[QB];
            for (int l = 0; l < L; l++) begin
                r_out[l] <= n_out[l];
            end
        end
    end

    assign o_valid     = r_vo;
    assign o_zero_norm = r_zn;
    assign o_r00 = r_out[0];
    assign o_r01 = r_out[1];
    assign o_r02 = r_out[2];
    assign o_r10 = r_out[3];
    assign o_r11 = r_out[4];
    assign o_r12 = r_out[5];
    assign o_r20 = r_out[6];
    assign o_r21 = r_out[7];
    assign o_r22 = r_out[8];

    logic signed [17:0] trace;
    assign trace = 18'(o_r00) + 18'(o_r11) + 18'(o_r22);

    `ASSERT_IMPL(a_zero_out, i_clk, i_rst_n, o_valid && o_zero_norm, o_r00 == 0 && o_r11 == 0 && o_r22 == 0 && o_r01 == 0 && o_r12 == 0 && o_r20 == 0, "null quaternion gave nonzero matrix")
    `ASSERT_IMPL(a_range, i_clk, i_rst_n, o_valid, o_r00 >= -16384 && o_r00 <= 16384 && o_r11 >= -16384 && o_r11 <= 16384 && o_r22 >= -16384 && o_r22 <= 16384, "diagonal element out of range")
    `ASSERT_IMPL(a_trace, i_clk, i_rst_n, o_valid && !o_zero_norm, trace >= -18'sd16387, "matrix trace below -1")
endmodule

### sim/quaternion_to_rotation_matrix_test.sv
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_test;

    // One expected rotation matrix, fields in output port order.
    typedef struct {
        logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic               zero_norm;
    } rot_matrix_t;

    // Scoreboard: predicts the matrix for each accepted quaternion and checks
    // each result against the oldest prediction.
    class rotation_scoreboard;
        rot_matrix_t pending_matrices[$];
        int          error_count;

        // Exact element num/n in Q1.14, nearest with ties away from zero, clamped.
        function automatic logic signed [15:0] scaled_ratio(longint num, longint norm_sq);
            longint mag;
            longint quo;
            mag = (num < 0) ? -num : num;
            quo = (mag * 32768 + norm_sq) / (2 * norm_sq);
            if (quo > 16384) begin
                quo = 16384;
            end
            if (num < 0) begin
                quo = -quo;
            end
            return quo[15:0];
        endfunction

        function void note_quaternion(logic signed [15:0] qx, logic signed [15:0] qy,
                                      logic signed [15:0] qz, logic signed [15:0] qw);
            longint x, y, z, w, xx, yy, zz, ww, nsq;
            rot_matrix_t m;
            x = qx; y = qy; z = qz; w = qw;
            xx = x * x; yy = y * y; zz = z * z; ww = w * w;
            nsq = xx + yy + zz + ww;
            if (nsq == 0) begin
                m = '{default: 0};
                m.zero_norm = 1'b1;
            end else begin
                m.r00 = scaled_ratio(nsq - 2 * (yy + zz), nsq);
                m.r01 = scaled_ratio(2 * (x * y - z * w), nsq);
                m.r02 = scaled_ratio(2 * (x * z + y * w), nsq);
                m.r10 = scaled_ratio(2 * (x * y + z * w), nsq);
                m.r11 = scaled_ratio(nsq - 2 * (xx + zz), nsq);
                m.r12 = scaled_ratio(2 * (y * z - x * w), nsq);
                m.r20 = scaled_ratio(2 * (x * z - y * w), nsq);
                m.r21 = scaled_ratio(2 * (y * z + x * w), nsq);
                m.r22 = scaled_ratio(nsq - 2 * (xx + yy), nsq);
                m.zero_norm = 1'b0;
            end
            pending_matrices.push_back(m);
        endfunction

        function void compare_field(string name, logic signed [15:0] exp_v,
                                    logic signed [15:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_matrix(rot_matrix_t act);
            rot_matrix_t exp_m;
            if (pending_matrices.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual r00=%0d",
                         $time, act.r00);
                error_count++;
                return;
            end
            exp_m = pending_matrices.pop_front();
            compare_field("r00", exp_m.r00, act.r00);
            compare_field("r01", exp_m.r01, act.r01);
            compare_field("r02", exp_m.r02, act.r02);
            compare_field("r10", exp_m.r10, act.r10);
            compare_field("r11", exp_m.r11, act.r11);
            compare_field("r12", exp_m.r12, act.r12);
            compare_field("r20", exp_m.r20, act.r20);
            compare_field("r21", exp_m.r21, act.r21);
            compare_field("r22", exp_m.r22, act.r22);
            compare_field("zero_norm", {15'd0, exp_m.zero_norm},
                          {15'd0, act.zero_norm});
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1030;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_quat_x = '0;
    logic signed [15:0] i_quat_y = '0;
    logic signed [15:0] i_quat_z = '0;
    logic signed [15:0] i_quat_w = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [15:0] o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;
    logic               o_zero_norm;

    rotation_scoreboard scoreboard = new();
    bit                 sending_done = 0;
    bit                 stall_loose = 0;
    int                 cycle_count = 0;

    quaternion_to_rotation_matrix DUT (.*);

    always #4 i_clk = ~i_clk;

    // Hang guard: end the run if it never drains.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Note each accepted quaternion and check each accepted matrix at the edge.
    always @(posedge i_clk) begin
        rot_matrix_t act;
        if (i_rst_n && i_valid && !o_stall) begin
            scoreboard.note_quaternion(i_quat_x, i_quat_y, i_quat_z, i_quat_w);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            act.r00 = o_r00; act.r01 = o_r01; act.r02 = o_r02;
            act.r10 = o_r10; act.r11 = o_r11; act.r12 = o_r12;
            act.r20 = o_r20; act.r21 = o_r21; act.r22 = o_r22;
            act.zero_norm = o_zero_norm;
            scoreboard.check_matrix(act);
        end
    end

    // Receiver: per result draw a random stall; some stretches never stall.
    initial begin
        int wait_cycles;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_cycles = stall_loose ? 0 : $urandom_range(0, 5);
            repeat (wait_cycles) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk iff o_valid);
        end
    end

    // Present one quaternion, after a random gap unless no_gap is set, and hold it until taken.
    task automatic send_quaternion(logic signed [15:0] qx, logic signed [15:0] qy,
                                   logic signed [15:0] qz, logic signed [15:0] qw,
                                   bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_quat_x <= qx;
        i_quat_y <= qy;
        i_quat_z <= qz;
        i_quat_w <= qw;
        @(posedge i_clk iff !o_stall);
    endtask

    function automatic logic signed [15:0] pick_component();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($signed($urandom_range(0, 6)) - 3);
            3:       return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] qx, qy, qz, qw;
        bit burst;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero quaternion, identity, axis rotations, extremes, ties.
        send_quaternion(0, 0, 0, 0, 0);
        send_quaternion(0, 0, 0, 1, 0);
        send_quaternion(0, 0, 0, -32768, 0);
        send_quaternion(1, 0, 0, 0, 0);
        send_quaternion(0, -1, 0, 0, 1);
        send_quaternion(0, 0, 32767, 0, 1);
        send_quaternion(-32768, -32768, -32768, -32768, 0);
        send_quaternion(32767, 32767, 32767, 32767, 0);
        send_quaternion(-32768, 32767, -32768, 32767, 1);
        send_quaternion(32767, -32768, 0, 0, 0);
        send_quaternion(1, 1, 1, 1, 0);
        send_quaternion(1, 1, 0, 0, 0);
        send_quaternion(1, 2, 0, 0, 0);
        send_quaternion(1, 1, 1, 0, 0);
        send_quaternion(3, 0, 0, 4, 1);
        send_quaternion(-1, 0, 0, 0, 0);
        send_quaternion(0, 0, 0, 0, 1);
        send_quaternion(16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 0);
        send_quaternion(16'shAAAA, 16'sh5555, 16'shFF00, 16'sh00FF, 0);

        // Random: mixed magnitudes, with bursts of back-to-back items and no stall.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0) begin
                burst = ($urandom_range(0, 2) == 0);
                stall_loose <= burst;
            end
            qx = pick_component();
            qy = pick_component();
            qz = pick_component();
            qw = pick_component();
            if ($urandom_range(0, 40) == 0) begin
                qx = 0; qy = 0; qz = 0; qw = 0;
            end
            send_quaternion(qx, qy, qz, qw, burst);
        end
        i_valid <= 1'b0;
        stall_loose <= 1'b0;

        // Drain: wait for every matrix, then idle so that a stray result would be caught.
        @(posedge i_clk iff scoreboard.pending_matrices.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.error_count == 0 && scoreboard.pending_matrices.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
